// File: rtl/nnrs_pkg.sv
// Shared widths, codes and item types of the nearest-neighbor RGB to RGBA scaler.
package nnrs_pkg;

  localparam int DIM_W      = 12;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int QUOT_W     = DIM_W + 1;
  localparam int CNT_W      = $clog2(QUOT_W + 1);
  localparam int PROD_W     = QUOT_W + DIM_W;
  localparam int CFG_IDX_W  = 2;

  localparam int NNRS_MAX_PIXELS = 524288;

  localparam logic [DIM_W-1:0]  SRC_WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RESET = 12'd480;
  localparam logic [DIM_W-1:0]  DST_WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]  DST_HEIGHT_RESET = 12'd480;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE     = 8'd255;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic              frame_start;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
  } req_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic [CHAN_W-1:0] out_alpha;
    logic [DIM_W-1:0]  dest_x;
    logic [DIM_W-1:0]  dest_y;
    logic              last;
  } rsp_item_t;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
    logic [DIM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [QUOT_W-1:0] quot;
    logic [DIM_W-1:0]  rem;
  } div_rsp_t;

endpackage

// File: rtl/nnrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nnrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/nnrs_div.sv
// Restoring divider that produces one quotient bit per cycle.
module nnrs_div
  import nnrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [QUOT_W-1:0] part;
  logic [QUOT_W-1:0] quot;
  logic [DIM_W-1:0]  divisor;
  logic [CNT_W-1:0]  count;
  logic [QUOT_W-1:0] shifted;
  logic [QUOT_W-1:0] diff;
  logic              fits;

  assign shifted = {part[QUOT_W-2:0], quot[QUOT_W-1]};
  assign fits    = shifted >= QUOT_W'(divisor);
  assign diff    = shifted - QUOT_W'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      part    <= '0;
      quot    <= req.dividend;
      divisor <= req.divisor;
      count   <= CNT_W'(QUOT_W);
    end else if (count != '0) begin
      part  <= fits ? diff : shifted;
      quot  <= {quot[QUOT_W-2:0], fits};
      count <= count - 1'b1;
    end
  end

  assign rsp.busy = count != '0;
  assign rsp.quot = quot;
  assign rsp.rem  = part[DIM_W-1:0];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && $past(count) == CNT_W'(1)) |-> (part < QUOT_W'(divisor)))
    else $error("Divider remainder is not below the divisor.");

endmodule

// File: rtl/nearest_neighbor_rgb_to_rgba_scaler.sv
// Top level of the nearest-neighbor RGB to RGBA scaler with its frame store and control.
//
// Usage: the request channel (req_valid, req_stall, req) carries one item per handshake.
// An item with op OP_STORE writes the next source pixel into the frame store in raster
// order; frame_start puts the write position back at pixel zero first. Writes past the
// store capacity are dropped. Such an item gives no result.
// An item with op OP_FETCH asks for the next destination pixel in raster order; the
// result leaves on the response channel (rsp_valid, rsp_stall, rsp) with alpha 255.
// A fetch passes from acceptance to the response register through the shared divider,
// a step that sees it finish and forms the row-stride product, one for the row base
// sum and one that loads the response. A new fetch is accepted only after the last one
// has loaded its response; stores run at one per clock while no fetch is in progress.
// A held response does not block stores. A fetch accepted while a response is held runs
// through the divider and then waits, with the input stalled, until the response register
// is free. While rsp_stall is high the response holds.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready.
// Write it only while idle; the block does not enforce this. A size of zero acts as one.
// Reset clears the positions and loads a 640 by 480 geometry; the store is not cleared.
module nearest_neighbor_rgb_to_rgba_scaler
  import nnrs_pkg::*;
#(
  parameter int MAX_PIXELS = NNRS_MAX_PIXELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_item_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_item_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_PIXELS);
  localparam int BW    = $clog2(MAX_PIXELS + 1);
  localparam int AD_W  = (BW > DIM_W ? BW : DIM_W) + 1;
  localparam int SUM_W = (BW > PROD_W ? BW : PROD_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;

  logic [DIM_W-1:0]  src_width, src_height, dst_width, dst_height;
  logic [DIM_W-1:0]  sw_e, sh_e, dw_e, dh_e;
  logic [BW-1:0]     write_position;
  logic [DIM_W-1:0]  dest_col, dest_row, src_col, col_rem, row_rem;
  logic [BW-1:0]     row_base;
  logic              row_end_r, frame_end_r, oob_r;
  logic [PROD_W-1:0] prod;

  logic              acc;
  logic [BW-1:0]     wp_cur;
  logic [DIM_W-1:0]  col_cur, row_cur, scol_cur, crem_cur, rrem_cur;
  logic [BW-1:0]     base_cur;
  logic              row_end, frame_end;
  logic [AD_W-1:0]   addr;
  logic [SUM_W-1:0]  base_sum;
  logic [PIX_W-1:0]  rd_data, pix;
  logic              wr_en, rd_en;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign sw_e = (src_width  == '0) ? DIM_W'(1) : src_width;
  assign sh_e = (src_height == '0) ? DIM_W'(1) : src_height;
  assign dw_e = (dst_width  == '0) ? DIM_W'(1) : dst_width;
  assign dh_e = (dst_height == '0) ? DIM_W'(1) : dst_height;

  assign req_stall = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign acc       = req_valid && !req_stall;

  assign wp_cur   = req.frame_start ? '0 : write_position;
  assign col_cur  = req.frame_start ? '0 : dest_col;
  assign row_cur  = req.frame_start ? '0 : dest_row;
  assign scol_cur = req.frame_start ? '0 : src_col;
  assign crem_cur = req.frame_start ? '0 : col_rem;
  assign rrem_cur = req.frame_start ? '0 : row_rem;
  assign base_cur = req.frame_start ? '0 : row_base;

  assign row_end   = col_cur >= dw_e - 1'b1;
  assign frame_end = row_end && (row_cur >= dh_e - 1'b1);
  assign addr      = AD_W'(base_cur) + AD_W'(scol_cur);

  assign wr_en = acc && req.op == OP_STORE && wp_cur < BW'(MAX_PIXELS);
  assign rd_en = acc && req.op == OP_FETCH;

  always_comb begin
    div_req.start = rd_en;
    if (row_end) begin
      div_req.dividend = QUOT_W'(rrem_cur) + QUOT_W'(sh_e);
      div_req.divisor  = dh_e;
    end else begin
      div_req.dividend = QUOT_W'(crem_cur) + QUOT_W'(sw_e);
      div_req.divisor  = dw_e;
    end
  end

  nnrs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wp_cur[AW-1:0]),
    .wr_data({req.chan2, req.chan1, req.chan0}),
    .rd_en  (rd_en),
    .rd_addr(addr[AW-1:0]),
    .rd_data(rd_data)
  );

  nnrs_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign pix      = oob_r ? '0 : rd_data;
  assign base_sum = SUM_W'(row_base) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      write_position <= '0;
      dest_col       <= '0;
      dest_row       <= '0;
      src_col        <= '0;
      col_rem        <= '0;
      row_rem        <= '0;
      row_base       <= '0;
      src_width      <= SRC_WIDTH_RESET;
      src_height     <= SRC_HEIGHT_RESET;
      dst_width      <= DST_WIDTH_RESET;
      dst_height     <= DST_HEIGHT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH:  src_width  <= cfg_data;
          REG_SRC_HEIGHT: src_height <= cfg_data;
          REG_DST_WIDTH:  dst_width  <= cfg_data;
          REG_DST_HEIGHT: dst_height <= cfg_data;
        endcase
      end
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && req.op == OP_STORE) begin
            write_position <= wr_en ? wp_cur + 1'b1 : wp_cur;
          end else if (acc) begin
            dest_col    <= col_cur;
            dest_row    <= row_cur;
            src_col     <= scol_cur;
            col_rem     <= crem_cur;
            row_rem     <= rrem_cur;
            row_base    <= base_cur;
            row_end_r   <= row_end;
            frame_end_r <= frame_end;
            oob_r       <= addr >= AD_W'(MAX_PIXELS);
            state       <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_rsp.busy) begin
            prod  <= div_rsp.quot * sw_e;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            rsp.out_chan0 <= pix[CHAN_W-1:0];
            rsp.out_chan1 <= pix[2*CHAN_W-1:CHAN_W];
            rsp.out_chan2 <= pix[3*CHAN_W-1:2*CHAN_W];
            rsp.out_alpha <= ALPHA_OPAQUE;
            rsp.dest_x    <= dest_col;
            rsp.dest_y    <= dest_row;
            rsp.last      <= frame_end_r;
            if (frame_end_r) begin
              dest_col <= '0;
              dest_row <= '0;
              src_col  <= '0;
              col_rem  <= '0;
              row_rem  <= '0;
              row_base <= '0;
            end else if (row_end_r) begin
              dest_col <= '0;
              src_col  <= '0;
              col_rem  <= '0;
              dest_row <= dest_row + 1'b1;
              row_rem  <= div_rsp.rem;
              row_base <= (base_sum > SUM_W'(MAX_PIXELS)) ? BW'(MAX_PIXELS)
                                                           : base_sum[BW-1:0];
            end else begin
              dest_col <= dest_col + 1'b1;
              col_rem  <= div_rsp.rem;
              src_col  <= src_col + div_rsp.quot[DIM_W-1:0];
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while still busy.");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("Response loaded outside the output state.");

  a_mul_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state == S_DIV) && !$past(div_rsp.busy)))
    else $error("Multiply step entered before the divider finished.");

  a_wp_bounded: assert property (@(posedge clk) disable iff (rst)
    write_position <= BW'(MAX_PIXELS))
    else $error("Write position ran past the store capacity.");

endmodule

// File: test/nearest_neighbor_rgb_to_rgba_scaler_test.sv
// Self-checking testbench for the nearest-neighbor RGB to RGBA scaler with a built-in predictor.
module nearest_neighbor_rgb_to_rgba_scaler_test;
  import nnrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_SRC_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  req_item_t pending_items[$];
  rsp_item_t expected_pixels[$];
  rsp_item_t want_pixel;
  int error_count = 0;
  bit idle_on = 1'b0;
  int send_gap = 0;
  int stall_gap = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_served = 0;

  logic [DIM_W-1:0] geom [4] = '{SRC_WIDTH_RESET, SRC_HEIGHT_RESET,
                                 DST_WIDTH_RESET, DST_HEIGHT_RESET};
  logic [PIX_W-1:0] shadow_store [NNRS_MAX_PIXELS];
  int unsigned store_wr_pos = 0;
  logic [DIM_W-1:0] out_col = '0;
  logic [DIM_W-1:0] out_row = '0;
  logic [DIM_W-1:0] smp_col = '0;
  logic [DIM_W-1:0] smp_col_rem = '0;
  logic [DIM_W-1:0] smp_row_rem = '0;
  int unsigned smp_row_base = 0;

  nearest_neighbor_rgb_to_rgba_scaler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_size(logic [DIM_W-1:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic string pixel_text(rsp_item_t p);
    return $sformatf("rgba=%02h %02h %02h %02h x=%0d y=%0d last=%0b", p.out_chan0,
                     p.out_chan1, p.out_chan2, p.out_alpha, p.dest_x, p.dest_y, p.last);
  endfunction

  task automatic restart_sampling();
    out_col = '0;
    out_row = '0;
    smp_col = '0;
    smp_col_rem = '0;
    smp_row_rem = '0;
    smp_row_base = 0;
  endtask

  task automatic predict_output_pixel(req_item_t item);
    int unsigned sw, sh, dw, dh, addr, acc;
    logic [PIX_W-1:0] pix;
    rsp_item_t pixel;
    logic row_end, frame_end;
    sw = eff_size(geom[REG_SRC_WIDTH]);
    sh = eff_size(geom[REG_SRC_HEIGHT]);
    dw = eff_size(geom[REG_DST_WIDTH]);
    dh = eff_size(geom[REG_DST_HEIGHT]);
    if (item.op == OP_STORE) begin
      if (item.frame_start) store_wr_pos = 0;
      if (store_wr_pos < NNRS_MAX_PIXELS) begin
        shadow_store[store_wr_pos] = {item.chan2, item.chan1, item.chan0};
        store_wr_pos++;
      end
    end else begin
      if (item.frame_start) restart_sampling();
      addr = smp_row_base + smp_col;
      pix = (addr < NNRS_MAX_PIXELS) ? shadow_store[addr] : '0;
      row_end = out_col >= dw - 1;
      frame_end = row_end && (out_row >= dh - 1);
      pixel.out_chan0 = pix[7:0];
      pixel.out_chan1 = pix[15:8];
      pixel.out_chan2 = pix[23:16];
      pixel.out_alpha = ALPHA_OPAQUE;
      pixel.dest_x = out_col;
      pixel.dest_y = out_row;
      pixel.last = frame_end;
      expected_pixels.push_back(pixel);
      if (frame_end) begin
        restart_sampling();
      end else if (row_end) begin
        out_col = '0;
        smp_col = '0;
        smp_col_rem = '0;
        out_row = out_row + 1'b1;
        acc = smp_row_rem + sh;
        smp_row_rem = DIM_W'(acc % dh);
        smp_row_base = smp_row_base + (acc / dh) * sw;
        if (smp_row_base > NNRS_MAX_PIXELS) smp_row_base = NNRS_MAX_PIXELS;
      end else begin
        out_col = out_col + 1'b1;
        acc = smp_col_rem + sw;
        smp_col_rem = DIM_W'(acc % dw);
        smp_col = DIM_W'(smp_col + acc / dw);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_output_pixel(req);
      end
      if (!req_valid || !req_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (idle_on && pending_items.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          req_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      rsp_stall <= 1'b1;
    end else if (stall_gap != 0) begin
      stall_gap--;
      rsp_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_gap = $urandom_range(0, 6);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_pixels.size() == 0) begin
        if (error_count < 10) $display("Unexpected result item: %s", pixel_text(rsp));
        error_count++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (rsp.out_chan0 !== want_pixel.out_chan0 || rsp.out_chan1 !== want_pixel.out_chan1 ||
            rsp.out_chan2 !== want_pixel.out_chan2 || rsp.out_alpha !== want_pixel.out_alpha ||
            rsp.dest_x !== want_pixel.dest_x || rsp.dest_y !== want_pixel.dest_y ||
            rsp.last !== want_pixel.last) begin
          if (error_count < 10) begin
            $display("Mismatch: expected %s, got %s", pixel_text(want_pixel), pixel_text(rsp));
          end
          error_count++;
        end
      end
    end
  end

  task automatic queue_item(op_t op, int unsigned start, int unsigned rgb);
    req_item_t item;
    item.op = op;
    item.frame_start = start[0];
    {item.chan2, item.chan1, item.chan0} = rgb[PIX_W-1:0];
    while (pending_items.size() >= 16) @(posedge clk);
    pending_items.push_back(item);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    geom[idx] = val;
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh);
    write_reg(REG_SRC_WIDTH, DIM_W'(sw));
    write_reg(REG_SRC_HEIGHT, DIM_W'(sh));
    write_reg(REG_DST_WIDTH, DIM_W'(dw));
    write_reg(REG_DST_HEIGHT, DIM_W'(dh));
  endtask

  function automatic int unsigned random_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(1, 4095);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Opens a frame with a fetch, then mostly fetches that walk on through it; stores and restarts are mixed in.
  task automatic random_traffic(int unsigned count);
    int unsigned k;
    queue_item(OP_FETCH, 1'b1, $urandom);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) queue_item(OP_STORE, $urandom_range(0, 1), $urandom);
        1: queue_item(OP_FETCH, $urandom_range(0, 1), $urandom);
        default: queue_item(OP_FETCH, 1'b0, $urandom);
      endcase
    end
  endtask

  initial begin
    int unsigned n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    queue_item(OP_STORE, 1'b1, 24'h000000);
    queue_item(OP_STORE, 1'b0, 24'hFFFFFF);
    queue_item(OP_FETCH, 1'b1, 24'hFFFFFF);
    queue_item(OP_FETCH, 1'b0, 24'h000000);
    wait_idle();

    set_geometry(3, 2, 2, 3);
    queue_item(OP_STORE, 1'b1, 24'hFF00FF);
    for (n = 0; n < 5; n++) queue_item(OP_STORE, 1'b0, $urandom);
    queue_item(OP_FETCH, 1'b1, $urandom);
    for (n = 0; n < 6; n++) queue_item(OP_FETCH, 1'b0, $urandom);
    wait_idle();

    // The random frames at the end use sources of at most 8 by 8 pixels, so these 64 entries cover them.
    idle_on = 1'b0;
    queue_item(OP_STORE, 1'b1, $urandom);
    for (n = 0; n < 63; n++) queue_item(OP_STORE, 1'b0, $urandom);
    wait_idle();

    idle_on = 1'b1;
    set_geometry(4095, 4095, 1, 2);
    queue_item(OP_FETCH, 1'b1, $urandom);
    queue_item(OP_FETCH, 1'b0, $urandom);
    queue_item(OP_FETCH, 1'b0, $urandom);
    wait_idle();

    set_geometry(0, 0, 0, 0);
    queue_item(OP_FETCH, 1'b1, $urandom);
    queue_item(OP_FETCH, 1'b0, $urandom);
    wait_idle();

    idle_on = 1'b0;
    set_geometry(1, 1, 4095, 4095);
    holds_asked++;
    random_traffic(36);
    wait_idle();

    idle_on = 1'b1;
    set_geometry(4095, 4095, 4095, 4095);
    random_traffic(36);
    wait_idle();

    for (n = 0; n < 9; n++) begin
      idle_on = (n < 7) && ($urandom_range(0, 3) != 0);
      set_geometry($urandom_range(0, 8), $urandom_range(0, 8), random_size(), random_size());
      random_traffic(36);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
